// File: sv/pcfr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the crc-16/ccitt-false byte update for the frame receiver
// no dependencies; imported by every module of the block

package pcfr_pkg;

  localparam logic [7:0]  PRE_FIRST   = 8'hB0;
  localparam logic [7:0]  PRE_SECOND  = 8'h5E;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [7:0]  MIN_LEN     = 8'd4;     // length byte below this gives a total under six
  localparam logic [8:0]  MIN_FULL    = 9'd10;
  localparam logic [8:0]  ACK_TOTAL   = 9'd14;
  localparam logic [3:0]  OP_EVENT    = 4'h4;
  localparam logic [3:0]  OP_RESP_8   = 4'h8;
  localparam logic [3:0]  OP_RESP_9   = 4'h9;
  localparam logic [3:0]  OP_RESP_A   = 4'hA;
  localparam logic [15:0] RST_TIMEOUT = 16'd6000;
  localparam logic [7:0]  RST_PROTO   = 8'h10;
  localparam logic [3:0]  RST_VERSION = 4'h0;
  localparam logic [15:0] RST_HB_PROP = 16'h0001;

  localparam int TDATA_OUT_W = 80;
  localparam int TDATA_IN_W  = 8;

  // status codes
  localparam logic [3:0] ST_ACK      = 4'd0;
  localparam logic [3:0] ST_EVENT    = 4'd1;
  localparam logic [3:0] ST_OTHER    = 4'd2;
  localparam logic [3:0] ST_RESP_ERR = 4'd3;
  localparam logic [3:0] ST_CRC_ERR  = 4'd4;
  localparam logic [3:0] ST_SHORT    = 4'd5;
  localparam logic [3:0] ST_PROTO    = 4'd6;
  localparam logic [3:0] ST_BAD_LEN  = 4'd7;
  localparam logic [3:0] ST_TIMEOUT  = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_PROTOCOL = 2'd1;
  localparam logic [1:0] CFG_VERSION  = 2'd2;
  localparam logic [1:0] CFG_HB_PROP  = 2'd3;

  // input item kind carried on tuser
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_LENGTH = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  // classified item passed from front to back
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
    logic       is_pre1;
    logic       is_pre2;
    logic       len_short;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        link_up;
    logic [3:0]  frame_operator;
    logic [7:0]  result_code;
    logic [15:0] prop_ident;
    logic [7:0]  value_length;
    logic [31:0] heartbeat_count;
    logic        version_mismatch;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [TDATA_OUT_W-1:0] pack_result(input result_t r);
    return {6'b0, r.version_mismatch, r.heartbeat_count, r.value_length, r.prop_ident,
            r.result_code, r.frame_operator, r.link_up, r.status};
  endfunction

  // inverse of pack_result, first field in the lowest bits
  function automatic result_t unpack_result(input logic [TDATA_OUT_W-1:0] d);
    result_t r;
    r.status           = d[3:0];
    r.link_up          = d[4];
    r.frame_operator   = d[8:5];
    r.result_code      = d[16:9];
    r.prop_ident       = d[32:17];
    r.value_length     = d[40:33];
    r.heartbeat_count  = d[72:41];
    r.version_mismatch = d[73];
    return r;
  endfunction

endpackage

// File: sv/pcfr_front.sv
`timescale 1ns / 1ps
// front end: accepts input beats, classifies them and queues them for the back end
// depends on pcfr_pkg

module pcfr_front #(
  parameter int DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [pcfr_pkg::TDATA_IN_W-1:0]    in_byte,
  output logic                               q_valid,
  output pcfr_pkg::item_t                    q_item,
  input  logic                               q_pop
);
  import pcfr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  item_t          cls;
  logic           push;

  always_comb begin
    cls.is_tick   = (in_kind == KIND_TICK);
    cls.rx_byte   = in_byte;
    cls.is_pre1   = (in_byte == PRE_FIRST);
    cls.is_pre2   = (in_byte == PRE_SECOND);
    cls.len_short = (in_byte < MIN_LEN);
  end

  assign in_ready = (count != FULL_CNT);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
      (push && !q_pop) |=> (count == $past(count) + 1'b1))
    else $error("push lost");

endmodule

// File: sv/pcfr_back.sv
`timescale 1ns / 1ps
// back end: frame hunt, crc check, classification, link supervision and output register
// depends on pcfr_pkg; fed by pcfr_front

module pcfr_back (
  input  logic                               clk,
  input  logic                               rst,
  input  pcfr_pkg::cfg_wr_t                  cfg_wr,
  input  logic                               q_valid,
  input  pcfr_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcfr_pkg::TDATA_OUT_W-1:0]   out_data
);
  import pcfr_pkg::*;

  logic [15:0] link_timeout_ticks;
  logic [7:0]  expected_protocol;
  logic [3:0]  expected_version;
  logic [15:0] heartbeat_property;

  phase_t      phase, phase_next;
  logic [8:0]  frame_total, frame_total_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  hdr_protocol, hdr_protocol_next;
  logic [7:0]  hdr_opver, hdr_opver_next;
  logic [7:0]  hdr_result, hdr_result_next;
  logic [15:0] hdr_property, hdr_property_next;
  logic [31:0] value_shift, value_shift_next;
  logic        link, link_next;
  logic [15:0] ticks, ticks_next;

  logic [15:0] crc_upd;
  logic [15:0] ticks_inc;
  logic [8:0]  idx_inc;
  logic [3:0]  op;
  logic        emit;
  result_t     res;
  result_t     out_res;

  assign q_pop   = q_valid && (!out_valid || out_ready);
  assign crc_upd = crc_byte(crc, q_item.rx_byte);
  assign op      = hdr_opver[3:0];
  assign out_res = unpack_result(out_data);

  always_comb begin
    phase_next        = phase;
    frame_total_next  = frame_total;
    byte_index_next   = byte_index;
    crc_next          = crc;
    hdr_protocol_next = hdr_protocol;
    hdr_opver_next    = hdr_opver;
    hdr_result_next   = hdr_result;
    hdr_property_next = hdr_property;
    value_shift_next  = value_shift;
    link_next         = link;
    ticks_next        = ticks;
    emit              = 1'b0;
    res               = '0;
    ticks_inc         = (ticks != 16'hFFFF) ? ticks + 16'd1 : ticks;
    idx_inc           = byte_index + 9'd1;

    if (q_pop) begin
      if (q_item.is_tick) begin
        ticks_next = ticks_inc;
        if (link && (ticks_inc > link_timeout_ticks)) begin
          link_next  = 1'b0;
          emit       = 1'b1;
          res.status = ST_TIMEOUT;
        end
      end else begin
        unique case (phase)
          PH_SECOND: begin
            if (q_item.is_pre2) begin
              crc_next   = crc_upd;
              phase_next = PH_LENGTH;
            end else if (q_item.is_pre1) begin
              crc_next   = crc_byte(CRC_INIT, q_item.rx_byte);
              phase_next = PH_SECOND;
            end else begin
              crc_next   = CRC_INIT;
              phase_next = PH_HUNT;
            end
          end
          PH_LENGTH: begin
            if (q_item.len_short) begin
              // rejected length byte restarts the hunt at itself
              if (q_item.is_pre1) begin
                crc_next   = crc_byte(CRC_INIT, q_item.rx_byte);
                phase_next = PH_SECOND;
              end else begin
                crc_next   = CRC_INIT;
                phase_next = PH_HUNT;
              end
              emit        = 1'b1;
              res.status  = ST_BAD_LEN;
              res.link_up = link;
            end else begin
              crc_next          = crc_upd;
              frame_total_next  = {1'b0, q_item.rx_byte} + 9'd2;
              byte_index_next   = 9'd3;
              hdr_protocol_next = '0;
              hdr_opver_next    = '0;
              hdr_result_next   = '0;
              hdr_property_next = '0;
              value_shift_next  = '0;
              phase_next        = PH_BODY;
            end
          end
          PH_BODY: begin
            crc_next        = crc_upd;
            byte_index_next = idx_inc;
            case (byte_index)
              9'd3: hdr_protocol_next = q_item.rx_byte;
              9'd4: hdr_opver_next = q_item.rx_byte;
              9'd5: hdr_result_next = q_item.rx_byte;
              9'd6: hdr_property_next = {q_item.rx_byte, 8'h00};
              9'd7: hdr_property_next = {hdr_property[15:8], q_item.rx_byte};
              default: begin
                if (({1'b0, byte_index} + 10'd2) < {1'b0, frame_total}) begin
                  value_shift_next = {value_shift[23:0], q_item.rx_byte};
                end
              end
            endcase
            if (idx_inc >= frame_total) begin
              // last frame beat: crc includes this byte; headers are settled unless the frame is short
              phase_next = PH_HUNT;
              crc_next   = CRC_INIT;
              emit       = 1'b1;
              if (crc_upd != 16'h0000) begin
                res.status = ST_CRC_ERR;
              end else if (frame_total < MIN_FULL) begin
                res.status = ST_SHORT;
              end else if (hdr_protocol != expected_protocol) begin
                res.status = ST_PROTO;
              end else if ((hdr_property == heartbeat_property) && (op == OP_RESP_A) &&
                           (hdr_result == 8'h00) && (frame_total == ACK_TOTAL)) begin
                res.status = ST_ACK;
                link_next  = 1'b1;
                ticks_next = 16'd0;
              end else if ((op == OP_RESP_8 || op == OP_RESP_9 || op == OP_RESP_A) &&
                           (hdr_result != 8'h00)) begin
                res.status = ST_RESP_ERR;
              end else if (op == OP_EVENT) begin
                res.status = ST_EVENT;
              end else begin
                res.status = ST_OTHER;
              end
              res.link_up = link_next;
              if (res.status <= ST_RESP_ERR) begin
                res.frame_operator   = op;
                res.result_code      = hdr_result;
                res.prop_ident       = hdr_property;
                res.value_length     = frame_total[7:0] - 8'd10;
                res.version_mismatch = (hdr_opver[7:4] != expected_version);
              end
              if (res.status == ST_ACK) begin
                res.heartbeat_count = value_shift;
              end
            end
          end
          default: begin
            if (q_item.is_pre1) begin
              crc_next   = crc_byte(CRC_INIT, q_item.rx_byte);
              phase_next = PH_SECOND;
            end else begin
              crc_next   = CRC_INIT;
              phase_next = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout_ticks <= RST_TIMEOUT;
      expected_protocol  <= RST_PROTO;
      expected_version   <= RST_VERSION;
      heartbeat_property <= RST_HB_PROP;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_TIMEOUT:  link_timeout_ticks <= cfg_wr.data;
        CFG_PROTOCOL: expected_protocol  <= cfg_wr.data[7:0];
        CFG_VERSION:  expected_version   <= cfg_wr.data[3:0];
        CFG_HB_PROP:  heartbeat_property <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      frame_total <= '0;
      byte_index  <= '0;
      crc         <= CRC_INIT;
      link        <= 1'b0;
      ticks       <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      frame_total <= frame_total_next;
      byte_index  <= byte_index_next;
      crc         <= crc_next;
      link        <= link_next;
      ticks       <= ticks_next;
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_protocol <= hdr_protocol_next;
    hdr_opver    <= hdr_opver_next;
    hdr_result   <= hdr_result_next;
    hdr_property <= hdr_property_next;
    value_shift  <= value_shift_next;
    if (q_pop && emit) begin
      out_data <= pack_result(res);
    end
  end

  a_ack_link: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_res.status == ST_ACK) |-> out_res.link_up)
    else $error("heartbeat ack without link up");
  a_timeout_link: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_res.status == ST_TIMEOUT) |-> !out_res.link_up)
    else $error("timeout with link up");
  a_count_ack_only: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_res.status != ST_ACK) |-> (out_res.heartbeat_count == 32'd0))
    else $error("heartbeat count on non-ack result");
  a_hunt_crc: assert property (@(posedge clk) (phase == PH_HUNT) |-> (crc == CRC_INIT))
    else $error("crc not at init while hunting");
  a_link_rise: assert property (@(posedge clk) disable iff (rst)
      $rose(link) |-> (out_valid && out_res.status == ST_ACK))
    else $error("link raised without ack result");

endmodule

// File: sv/preamble_crc_frame_receiver_core.sv
`timescale 1ns / 1ps
// an accepted beat waits in a queue slot, then its result is registered onto m_axis
// throughput: one beat (byte or tick) per cycle unless m_axis stalls; the crc byte update
// and frame state advance once per cycle in the back end, fed from a QUEUE_DEPTH-entry queue
// reset (rst, synchronous): hunt restarts, link down, tick count zero, registers at defaults
// top level of the framed receiver; depends on pcfr_pkg, pcfr_front and pcfr_back

module preamble_crc_frame_receiver_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pcfr_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // rx_byte
  input  logic                               s_axis_tuser,   // item kind, byte or tick
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status, link_up, frame_operator, result_code, property id, value_length,
  // heartbeat_count, version_mismatch, zero fill
  output logic [pcfr_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data
);
  import pcfr_pkg::*;

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  pcfr_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pcfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: dv/pcfr_tb_pkg.sv
`timescale 1ns / 1ps
// status predictor and scoreboard for the framed receiver testbench
// depends on pcfr_pkg for status codes, register indexes and the result layout

package pcfr_tb_pkg;

  import pcfr_pkg::*;

  class frame_status_board;

    // register copies
    logic [15:0] timeout_ticks;
    logic [7:0]  want_proto;
    logic [3:0]  want_version;
    logic [15:0] ack_property;

    // receiver state
    phase_t      phase;
    logic [8:0]  total;
    logic [8:0]  idx;
    logic [15:0] crc;
    logic [7:0]  proto;
    logic [7:0]  opver;
    logic [7:0]  res;
    logic [15:0] prop;
    logic [31:0] count_shift;
    logic        link;
    logic [15:0] ticks;

    result_t     expected_status[$];
    int          errors;

    function new();
      timeout_ticks = RST_TIMEOUT;
      want_proto    = RST_PROTO;
      want_version  = RST_VERSION;
      ack_property  = RST_HB_PROP;
      phase         = PH_HUNT;
      total         = '0;
      idx           = '0;
      crc           = CRC_INIT;
      proto         = '0;
      opver         = '0;
      res           = '0;
      prop          = '0;
      count_shift   = '0;
      link          = 1'b0;
      ticks         = '0;
      errors        = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [15:0] value);
      case (index)
        CFG_TIMEOUT:  timeout_ticks = value;
        CFG_PROTOCOL: want_proto = value[7:0];
        CFG_VERSION:  want_version = value[3:0];
        CFG_HB_PROP:  ack_property = value;
        default: ;
      endcase
    endfunction

    // msb-first bitwise update, feedback taken against each data bit
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    // a byte that breaks the preamble may itself start a new one
    function void restart_at(logic [7:0] b);
      if (b == PRE_FIRST) begin
        phase = PH_SECOND;
        crc = crc_step(CRC_INIT, b);
      end else begin
        phase = PH_HUNT;
        crc = CRC_INIT;
      end
    endfunction

    function result_t close_frame();
      result_t    r;
      logic [3:0] op;
      r = '0;
      op = opver[3:0];
      phase = PH_HUNT;
      if (crc != 16'h0000) begin
        r.status = ST_CRC_ERR;
      end else if (total < MIN_FULL) begin
        r.status = ST_SHORT;
      end else if (proto != want_proto) begin
        r.status = ST_PROTO;
      end else if (prop == ack_property && op == OP_RESP_A && res == 8'h00 &&
                   total == ACK_TOTAL) begin
        r.status = ST_ACK;
        link = 1'b1;
        ticks = '0;
      end else if ((op == OP_RESP_8 || op == OP_RESP_9 || op == OP_RESP_A) && res != 8'h00) begin
        r.status = ST_RESP_ERR;
      end else if (op == OP_EVENT) begin
        r.status = ST_EVENT;
      end else begin
        r.status = ST_OTHER;
      end
      r.link_up = link;
      if (r.status <= ST_RESP_ERR) begin
        r.frame_operator   = op;
        r.result_code      = res;
        r.prop_ident       = prop;
        r.value_length     = 8'(total - MIN_FULL);
        r.version_mismatch = (opver[7:4] != want_version);
      end
      if (r.status == ST_ACK) r.heartbeat_count = count_shift;
      crc = CRC_INIT;
      return r;
    endfunction

    // called for every accepted input beat
    function void note_beat(logic kind, logic [7:0] b);
      result_t r;
      bit      emit;
      r = '0;
      emit = 0;
      if (kind == KIND_TICK) begin
        if (ticks != 16'hFFFF) ticks++;
        if (link && ticks > timeout_ticks) begin
          link = 1'b0;
          r.status = ST_TIMEOUT;
          emit = 1;
        end
      end else begin
        case (phase)
          PH_SECOND: begin
            if (b == PRE_SECOND) begin
              crc = crc_step(crc, b);
              phase = PH_LENGTH;
            end else begin
              restart_at(b);
            end
          end
          PH_LENGTH: begin
            if (b < MIN_LEN) begin
              restart_at(b);
              r.status = ST_BAD_LEN;
              r.link_up = link;
              emit = 1;
            end else begin
              crc = crc_step(crc, b);
              total = 9'(b) + 9'd2;
              idx = 9'd3;
              proto = '0;
              opver = '0;
              res = '0;
              prop = '0;
              count_shift = '0;
              phase = PH_BODY;
            end
          end
          PH_BODY: begin
            crc = crc_step(crc, b);
            if (idx == 9'd3) proto = b;
            else if (idx == 9'd4) opver = b;
            else if (idx == 9'd5) res = b;
            else if (idx == 9'd6) prop = {b, 8'h00};
            else if (idx == 9'd7) prop[7:0] = b;
            else if (idx + 9'd2 < total) count_shift = {count_shift[23:0], b};
            idx++;
            if (idx >= total) begin
              r = close_frame();
              emit = 1;
            end
          end
          default: restart_at(b);
        endcase
      end
      if (emit) expected_status.insert(expected_status.size(), r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [TDATA_OUT_W-1:0] d);
      result_t want;
      if (expected_status.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%0h", d);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      compare("status", 32'(want.status), 32'(d[3:0]));
      compare("link_up", 32'(want.link_up), 32'(d[4]));
      compare("frame_operator", 32'(want.frame_operator), 32'(d[8:5]));
      compare("result_code", 32'(want.result_code), 32'(d[16:9]));
      compare("prop_ident", 32'(want.prop_ident), 32'(d[32:17]));
      compare("value_length", 32'(want.value_length), 32'(d[40:33]));
      compare("heartbeat_count", want.heartbeat_count, d[72:41]);
      compare("version_mismatch", 32'(want.version_mismatch), 32'(d[73]));
    endfunction

  endclass

endpackage

// File: dv/preamble_crc_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for preamble_crc_frame_receiver_core: directed frames, then
// random frame traffic with ticks over several register settings; uses pcfr_pkg, pcfr_tb_pkg

module preamble_crc_frame_receiver_core_tb;

  import pcfr_pkg::*;
  import pcfr_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = KIND_BYTE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = CFG_TIMEOUT;
  logic [15:0]            cfg_data = '0;

  frame_status_board status_board;
  logic [7:0]        frame_buf[$];
  int                beats_sent = 0;
  int                idle_run = 0;
  int                rx_wait = 0;
  bit                steady = 0;

  preamble_crc_frame_receiver_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if (steady) return 0;
    return $urandom_range(0, 7);
  endfunction

  // result side: random stall after each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      status_board.check_status(m_axis_tdata);
      rx_wait = pick_gap();
      m_axis_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      if (rx_wait == 0) m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic send_beat(input logic kind, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    status_board.note_beat(kind, b);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(KIND_TICK, 8'($urandom));
  endtask

  // tick_pct: chance in percent of a tick slipped in before each byte
  task automatic drive_frame(input int tick_pct);
    foreach (frame_buf[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_beat(KIND_BYTE, frame_buf[i]);
    end
  endtask

  // header, filler, big-endian count in the last four body bytes, crc msb first
  task automatic build_frame(input logic [7:0] len, input logic [7:0] proto,
                             input logic [7:0] opver, input logic [7:0] res,
                             input logic [15:0] prop, input logic [31:0] count,
                             input bit corrupt);
    int          total;
    int          pos;
    logic [7:0]  b;
    logic [15:0] c;
    total = int'(len) + 2;
    frame_buf = {PRE_FIRST, PRE_SECOND, len};
    for (int i = 3; i < total - 2; i++) begin
      case (i)
        3: b = proto;
        4: b = opver;
        5: b = res;
        6: b = prop[15:8];
        7: b = prop[7:0];
        default: b = (i >= total - 6) ? count[8 * (total - 3 - i) +: 8] : 8'($urandom);
      endcase
      frame_buf.insert(frame_buf.size(), b);
    end
    c = CRC_INIT;
    foreach (frame_buf[i]) c = frame_status_board::crc_step(c, frame_buf[i]);
    frame_buf.insert(frame_buf.size(), c[15:8]);
    frame_buf.insert(frame_buf.size(), c[7:0]);
    if (corrupt) begin
      pos = $urandom_range(3, total - 1);
      frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  // hold off the sender until every expected result is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (status_board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] tmo, input logic [7:0] proto,
                              input logic [3:0] ver, input logic [15:0] hbp);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{CFG_TIMEOUT, CFG_PROTOCOL, CFG_VERSION, CFG_HB_PROP};
    val = '{tmo, {8'h00, proto}, {12'h000, ver}, hbp};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      status_board.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_ack(input logic [31:0] count);
    build_frame(8'(ACK_TOTAL - 9'd2), status_board.want_proto,
                {status_board.want_version, OP_RESP_A}, 8'h00, status_board.ack_property,
                count, 0);
    drive_frame(0);
  endtask

  // mostly well-formed frames with random content, the rest noise and broken headers
  task automatic random_batch(input int quota);
    int          stop_at;
    int          pick;
    int          n;
    logic [7:0]  len;
    logic [7:0]  proto;
    logic [7:0]  res;
    logic [3:0]  op;
    logic [3:0]  ver;
    logic [15:0] prop;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) steady = !steady;
      if ($urandom_range(0, 39) == 0) drain();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(MIN_LEN, 255));
        else if ($urandom_range(0, 2) == 0) len = 8'(ACK_TOTAL - 9'd2);
        else len = 8'($urandom_range(MIN_LEN, 16));
        proto = ($urandom_range(0, 4) != 0) ? status_board.want_proto : 8'($urandom);
        ver = ($urandom_range(0, 9) < 7) ? status_board.want_version : 4'($urandom);
        case ($urandom_range(0, 4))
          0: op = OP_EVENT;
          1: op = OP_RESP_8;
          2: op = OP_RESP_9;
          3: op = OP_RESP_A;
          default: op = 4'($urandom);
        endcase
        res = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        prop = ($urandom_range(0, 9) < 6) ? status_board.ack_property : 16'($urandom);
        build_frame(len, proto, {ver, op}, res, prop, $urandom, $urandom_range(0, 9) == 0);
        drive_frame(8);
      end else if (pick < 70) begin
        send_beat(KIND_BYTE, PRE_FIRST);
        send_beat(KIND_BYTE, PRE_SECOND);
        send_beat(KIND_BYTE, 8'($urandom_range(0, MIN_LEN - 1)));
      end else if (pick < 80) begin
        send_beat(KIND_BYTE, PRE_FIRST);
        send_beat(KIND_BYTE, 8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_beat(KIND_BYTE, 8'($urandom));
      end else begin
        n = int'(status_board.timeout_ticks) + 2;
        if (n > 60) n = 60;
        repeat ($urandom_range(1, n)) send_tick();
      end
    end
    steady = 0;
  endtask

  initial begin
    status_board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under reset register values
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hFF);
    send_tick();                               // link down, no result
    send_ack(32'hFFFF_FFFF);
    build_frame(8'd8, 8'h10, 8'hF4, 8'h00, 16'hFFFF, 32'h0, 0);   // event, version mismatch
    drive_frame(0);
    build_frame(8'd9, 8'h10, 8'h08, 8'hFF, 16'h0000, 32'h0, 0);
    drive_frame(0);
    build_frame(8'd10, 8'h10, 8'h09, 8'h01, 16'h1234, 32'h0, 0);
    drive_frame(0);
    build_frame(8'd12, 8'h10, 8'h0A, 8'h80, 16'h0001, 32'h0, 0);  // ack shape, result set
    drive_frame(0);
    build_frame(8'd12, 8'h10, 8'h0A, 8'h00, 16'h0002, 32'h0, 0);  // ack shape, other property
    drive_frame(0);
    build_frame(8'd13, 8'h10, 8'h0A, 8'h00, 16'h0001, 32'h0, 0);  // ack fields, wrong size
    drive_frame(0);
    build_frame(8'd8, 8'h10, 8'h00, 8'h00, 16'h0001, 32'h0, 0);
    drive_frame(0);
    build_frame(8'd12, 8'h10, 8'h0A, 8'h00, 16'h0001, 32'h0, 1);  // crc error
    drive_frame(0);
    build_frame(MIN_LEN, 8'h10, 8'h04, 8'h00, 16'h0, 32'h0, 0);   // shortest frame
    drive_frame(0);
    build_frame(8'd7, 8'h10, 8'h04, 8'h00, 16'h0, 32'h0, 0);
    drive_frame(0);
    build_frame(8'd8, 8'h11, 8'h04, 8'h00, 16'h0, 32'h0, 0);      // wrong protocol
    drive_frame(0);
    send_beat(KIND_BYTE, PRE_FIRST);
    send_beat(KIND_BYTE, PRE_SECOND);
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, PRE_FIRST);
    send_beat(KIND_BYTE, PRE_SECOND);
    send_beat(KIND_BYTE, MIN_LEN - 8'd1);
    // preamble restart on a repeated first byte
    send_beat(KIND_BYTE, PRE_FIRST);
    build_frame(8'd8, 8'h10, 8'h04, 8'h00, 16'h0, 32'h0, 0);
    drive_frame(0);
    send_beat(KIND_BYTE, PRE_FIRST);
    send_beat(KIND_BYTE, 8'h12);
    build_frame(8'd255, 8'h10, 8'h04, 8'h00, 16'hBEEF, 32'h1234_5678, 0);  // longest frame
    drive_frame(5);
    send_tick();

    program_regs(16'd1, 8'h00, 4'hF, 16'hFFFF);
    send_ack(32'h0000_0000);
    send_tick();
    send_tick();                               // link drops
    send_tick();
    random_batch(12);

    // largest timeout never expires over a run of ticks
    program_regs(16'hFFFF, 8'hFF, 4'h0, 16'h0000);
    send_ack($urandom);
    steady = 1;
    repeat (20) send_tick();
    steady = 0;
    program_regs(16'hFFFE, 8'hFF, 4'h0, 16'h0000);
    send_tick();
    random_batch(12);

    repeat (3) begin
      program_regs(16'($urandom_range(1, 40)), 8'($urandom), 4'($urandom), 16'($urandom));
      random_batch(12);
    end

    settle();
    if (status_board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
